### hdl/cmve_pkg.sv
package cmve_pkg;

  // Matrix dimension: DIM x DIM matrix, DIM-entry vector
  localparam int DIM      = 16;
  localparam int IdxW     = (DIM > 1) ? $clog2(DIM) : 1;
  localparam int AddrW    = (DIM > 1) ? $clog2(DIM * DIM) : 1;
  // two 32-bit products per term, DIM terms per row
  localparam int AccW     = 34 + $clog2(DIM);

  localparam int InDataW  = 48;
  localparam int OutDataW = 40;

  localparam int FracW    = 11;
  localparam int OneQ     = 2048;
  localparam int RndHalf  = 1024;
  localparam int SatMax   = 32767;
  localparam int SatMin   = -32768;

  typedef enum logic [2:0] {
    OP_SET   = 3'd0,
    OP_ADD   = 3'd1,
    OP_MUL   = 3'd2,
    OP_IDENT = 3'd3,
    OP_CLEAR = 3'd4,
    OP_VEC   = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_ADD,
    ST_WAIT
  } state_e;

  typedef struct packed {
    logic signed [15:0] im;
    logic signed [15:0] re;
  } cplx_t;

  function automatic logic in_range(input logic [3:0] v);
    return int'(v) < DIM;
  endfunction

  function automatic logic [AddrW-1:0] mat_addr(input logic [IdxW-1:0] r,
                                                input logic [IdxW-1:0] c);
    return AddrW'(int'(r) * DIM + int'(c));
  endfunction

  function automatic logic signed [15:0] sat_add(input logic signed [15:0] a,
                                                 input logic signed [15:0] b);
    logic signed [16:0] s;
    s = 17'(a) + 17'(b);
    if (s > 17'(SatMax)) begin
      return 16'(SatMax);
    end else if (s < 17'(SatMin)) begin
      return 16'(SatMin);
    end
    return 16'(s);
  endfunction

  // 22 -> 11 fraction bits, halves toward +inf, then saturate
  function automatic logic signed [15:0] round_sat(input logic signed [AccW-1:0] v);
    logic signed [AccW:0] t;
    t = (AccW+1)'(v) + (AccW+1)'(RndHalf);
    t = t >>> FracW;
    if (t > (AccW+1)'(SatMax)) begin
      return 16'(SatMax);
    end else if (t < (AccW+1)'(SatMin)) begin
      return 16'(SatMin);
    end
    return 16'(t);
  endfunction

endpackage

### hdl/complex_matrix_vector_engine_core.sv
// Complex matrix-vector engine, Q4.11 fixed point.
// Input words arrive on the s_axis channel, one operation per word: set, add to
// or complex-multiply one matrix entry, load identity, clear, or store one
// vector element. tlast on a vector-element word starts the product; the DIM
// row results leave on m_axis in row order, tlast on the final row.
// Set, identity, clear and vector store finish on acceptance; add reads the
// entry and writes back the saturated sum; entry multiply writes back the
// rounded MAC result. A product issues each row's entries, then waits for its
// sum. One complex MAC (four 16x16 multipliers), shared by entry multiply and
// the product, takes one entry per issue cycle behind the registered RAM read.
// The input is not ready while an operation is in progress.
// At reset the matrix reads as identity (per-entry valid bits, no clearing
// pass) and the vector is zero. A stalled receiver holds the output register;
// the next row waits in the accumulator, and the sequencer waits with it.
module complex_matrix_vector_engine_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  // op[2:0], row[6:3], col[10:7], re[26:11], im[42:27], zero fill above
  input  logic [cmve_pkg::InDataW-1:0] s_axis_tdata_i,
  input  logic                         s_axis_tlast_i,
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  // out_row[3:0], out_re[19:4], out_im[35:20], zero fill above
  output logic [cmve_pkg::OutDataW-1:0] m_axis_tdata_o,
  output logic                         m_axis_tlast_o
);

  localparam int IdxW  = cmve_pkg::IdxW;
  localparam int AddrW = cmve_pkg::AddrW;
  localparam int AccW  = cmve_pkg::AccW;
  localparam int Dim   = cmve_pkg::DIM;

  // input word fields
  cmve_pkg::op_e      in_op;
  logic [3:0]         in_row;
  logic [3:0]         in_col;
  cmve_pkg::cplx_t    in_val;
  logic               accept;

  assign in_op      = cmve_pkg::op_e'(s_axis_tdata_i[2:0]);
  assign in_row     = s_axis_tdata_i[6:3];
  assign in_col     = s_axis_tdata_i[10:7];
  assign in_val.re  = s_axis_tdata_i[26:11];
  assign in_val.im  = s_axis_tdata_i[42:27];
  assign accept     = s_axis_tvalid_i && s_axis_tready_o;

  // sequencer state
  cmve_pkg::state_e   state_q, state_d;
  cmve_pkg::op_e      op_q, op_d;
  logic [IdxW-1:0]    i_q, i_d;
  logic [IdxW-1:0]    j_q, j_d;
  cmve_pkg::cplx_t    a_q, a_d;

  // storage
  cmve_pkg::cplx_t    vec_q [Dim];
  logic [Dim*Dim-1:0] mvalid_q;
  logic               ident_q, ident_d;
  logic               mv_clr;
  logic               vec_we;

  // matrix RAM port signals
  logic               wr_en;
  logic [AddrW-1:0]   wr_addr;
  cmve_pkg::cplx_t    wr_data;
  logic [AddrW-1:0]   rd_addr;
  cmve_pkg::cplx_t    rd_data;

  // MAC pipeline
  logic               issue, issue_mul;
  logic               s1_vld_q, s1_first_q, s1_last_q, s1_diag_q, s1_mv_q;
  cmve_pkg::cplx_t    y1_q;
  cmve_pkg::cplx_t    x_eff;
  logic signed [31:0] p_rr_q, p_ii_q, p_ri_q, p_ir_q;
  logic               s2_vld_q, s2_first_q, s2_last_q;
  logic signed [AccW-1:0] acc_re_q, acc_im_q;
  logic               done_q, done_clr;

  // output register
  logic               m_vld_q, m_last_q, m_load, m_free;
  logic [3:0]         m_row_q;
  logic signed [15:0] m_re_q, m_im_q;

  assign m_free  = !m_vld_q || m_axis_tready_i;
  assign rd_addr = cmve_pkg::mat_addr(i_q, j_q);

  cmve_ram #(
    .Width ($bits(cmve_pkg::cplx_t)),
    .Depth (Dim * Dim)
  ) u_mat_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  // entry seen by the MAC / adder: unwritten entries follow the fill pattern
  always_comb begin
    if (s1_mv_q) begin
      x_eff = rd_data;
    end else begin
      x_eff.re = (ident_q && s1_diag_q) ? 16'(cmve_pkg::OneQ) : '0;
      x_eff.im = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cmve_pkg::ST_IDLE;
      op_q    <= cmve_pkg::OP_SET;
      i_q     <= '0;
      j_q     <= '0;
      ident_q <= 1'b1;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      i_q     <= i_d;
      j_q     <= j_d;
      ident_q <= ident_d;
    end
  end

  always_comb begin
    state_d         = state_q;
    op_d            = op_q;
    i_d             = i_q;
    j_d             = j_q;
    a_d             = a_q;
    ident_d         = ident_q;
    mv_clr          = 1'b0;
    vec_we          = 1'b0;
    wr_en           = 1'b0;
    wr_addr         = rd_addr;
    wr_data         = in_val;
    issue           = 1'b0;
    done_clr        = 1'b0;
    m_load          = 1'b0;
    s_axis_tready_o = 1'b0;

    case (state_q)
      cmve_pkg::ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i) begin
          op_d = in_op;
          a_d  = in_val;
          case (in_op)
            cmve_pkg::OP_SET: begin
              if (cmve_pkg::in_range(in_row) && cmve_pkg::in_range(in_col)) begin
                wr_en   = 1'b1;
                wr_addr = cmve_pkg::mat_addr(IdxW'(in_row), IdxW'(in_col));
              end
            end
            cmve_pkg::OP_ADD, cmve_pkg::OP_MUL: begin
              if (cmve_pkg::in_range(in_row) && cmve_pkg::in_range(in_col)) begin
                i_d     = IdxW'(in_row);
                j_d     = IdxW'(in_col);
                state_d = cmve_pkg::ST_ISSUE;
              end
            end
            cmve_pkg::OP_IDENT: begin
              mv_clr  = 1'b1;
              ident_d = 1'b1;
            end
            cmve_pkg::OP_CLEAR: begin
              mv_clr  = 1'b1;
              ident_d = 1'b0;
            end
            cmve_pkg::OP_VEC: begin
              vec_we = cmve_pkg::in_range(in_col);
              if (s_axis_tlast_i) begin
                i_d     = '0;
                j_d     = '0;
                state_d = cmve_pkg::ST_ISSUE;
              end
            end
            default: begin
            end
          endcase
        end
      end

      cmve_pkg::ST_ISSUE: begin
        issue = 1'b1;
        case (op_q)
          cmve_pkg::OP_ADD: state_d = cmve_pkg::ST_ADD;
          cmve_pkg::OP_MUL: state_d = cmve_pkg::ST_WAIT;
          default: begin
            if (j_q == IdxW'(Dim - 1)) begin
              j_d     = '0;
              state_d = cmve_pkg::ST_WAIT;
            end else begin
              j_d = j_q + IdxW'(1);
            end
          end
        endcase
      end

      cmve_pkg::ST_ADD: begin
        wr_en      = 1'b1;
        wr_data.re = cmve_pkg::sat_add(x_eff.re, a_q.re);
        wr_data.im = cmve_pkg::sat_add(x_eff.im, a_q.im);
        state_d    = cmve_pkg::ST_IDLE;
      end

      cmve_pkg::ST_WAIT: begin
        if (done_q) begin
          if (op_q == cmve_pkg::OP_MUL) begin
            wr_en      = 1'b1;
            wr_data.re = cmve_pkg::round_sat(acc_re_q);
            wr_data.im = cmve_pkg::round_sat(acc_im_q);
            done_clr   = 1'b1;
            state_d    = cmve_pkg::ST_IDLE;
          end else if (m_free) begin
            m_load   = 1'b1;
            done_clr = 1'b1;
            if (i_q == IdxW'(Dim - 1)) begin
              i_d     = '0;
              state_d = cmve_pkg::ST_IDLE;
            end else begin
              i_d     = i_q + IdxW'(1);
              state_d = cmve_pkg::ST_ISSUE;
            end
          end
        end
      end

      default: state_d = cmve_pkg::ST_IDLE;
    endcase
  end

  assign issue_mul = issue && (op_q != cmve_pkg::OP_ADD);

  // operand, vector and valid-bit storage
  always_ff @(posedge clk_i) begin
    a_q <= a_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < Dim; k++) begin
        vec_q[k] <= '0;
      end
      mvalid_q <= '0;
    end else begin
      if (vec_we) begin
        vec_q[IdxW'(in_col)] <= in_val;
      end
      if (mv_clr) begin
        mvalid_q <= '0;
      end else if (wr_en) begin
        mvalid_q[wr_addr] <= 1'b1;
      end
    end
  end

  // MAC pipeline control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      s1_vld_q <= issue_mul;
      s2_vld_q <= s1_vld_q;
      done_q   <= (s2_vld_q && s2_last_q) || (done_q && !done_clr);
    end
  end

  // MAC pipeline payload
  always_ff @(posedge clk_i) begin
    if (issue) begin
      s1_first_q <= (op_q == cmve_pkg::OP_MUL) || (j_q == '0);
      s1_last_q  <= (op_q == cmve_pkg::OP_MUL) || (j_q == IdxW'(Dim - 1));
      s1_diag_q  <= (i_q == j_q);
      s1_mv_q    <= mvalid_q[rd_addr];
      y1_q       <= (op_q == cmve_pkg::OP_MUL) ? a_q : vec_q[j_q];
    end
    if (s1_vld_q) begin
      p_rr_q     <= y1_q.re * x_eff.re;
      p_ii_q     <= y1_q.im * x_eff.im;
      p_ri_q     <= y1_q.re * x_eff.im;
      p_ir_q     <= y1_q.im * x_eff.re;
      s2_first_q <= s1_first_q;
      s2_last_q  <= s1_last_q;
    end
    if (s2_vld_q) begin
      acc_re_q <= (s2_first_q ? AccW'(0) : acc_re_q) + AccW'(p_rr_q) - AccW'(p_ii_q);
      acc_im_q <= (s2_first_q ? AccW'(0) : acc_im_q) + AccW'(p_ri_q) + AccW'(p_ir_q);
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q <= 1'b0;
    end else begin
      m_vld_q <= m_load || (m_vld_q && !m_axis_tready_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (m_load) begin
      m_row_q  <= 4'(i_q);
      m_re_q   <= cmve_pkg::round_sat(acc_re_q);
      m_im_q   <= cmve_pkg::round_sat(acc_im_q);
      m_last_q <= (i_q == IdxW'(Dim - 1));
    end
  end

  assign m_axis_tvalid_o = m_vld_q;
  assign m_axis_tlast_o  = m_last_q;
  assign m_axis_tdata_o  = {4'b0, m_im_q, m_re_q, m_row_q};

  // a finished sum only waits while the sequencer is waiting for it
  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> state_q == cmve_pkg::ST_WAIT)
    else $error("accumulator result pending outside wait state");

  // the multiplier stage is only fed by an issue cycle
  a_s1_from_issue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_vld_q |-> $past(state_q) == cmve_pkg::ST_ISSUE)
    else $error("multiplier stage loaded without issue");

  // a new output word only comes from the wait state
  a_out_from_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_vld_q) |-> $past(state_q) == cmve_pkg::ST_WAIT && $past(done_q))
    else $error("output loaded without a finished row");

  // identity or clear drops every written entry
  a_fill_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (in_op == cmve_pkg::OP_IDENT || in_op == cmve_pkg::OP_CLEAR)
    |=> mvalid_q == '0)
    else $error("matrix valid bits not cleared");

  // no RAM write while reads are being issued
  a_no_write_on_issue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == cmve_pkg::ST_ISSUE |-> !wr_en)
    else $error("matrix write during issue");

endmodule

### hdl/cmve_ram.sv
module cmve_ram #(
  parameter int Width = 32,
  parameter int Depth = 256,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
